// ===== src/lppi_pkg.sv =====
// Package for the lattice predator-prey interaction block.
// Holds field widths, register reset values, request/outcome codes and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package lppi_pkg;

	// field widths
	localparam int CELL_W     = 3;
	localparam int CNT_W      = 17;
	localparam int PROB_W     = 17;
	localparam int MATRIX_W   = 25;
	localparam int DRAW_W     = 16;
	localparam int REQ_W      = 2;
	localparam int DIR_W      = 2;
	localparam int CRD_W      = 8;
	localparam int OUTCOME_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;

	// counters kept: empty plus the five reported species
	localparam int NUM_CNT = 6;

	// parameter defaults
	localparam int DEF_ROWS    = 256;
	localparam int DEF_COLS    = 256;
	localparam int DEF_SPECIES = 5;

	// register reset values
	localparam logic [PROB_W-1:0]   MOB_RESET    = 17'd32768;
	localparam logic [PROB_W-1:0]   PRED_RESET   = 17'd16384;
	localparam logic [MATRIX_W-1:0] MATRIX_RESET = 25'd7989134;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MOB    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX = 2'd2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WRITE    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INTERACT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;

	// neighbour directions
	localparam logic [DIR_W-1:0] DIR_ROW_INC = 2'd0;
	localparam logic [DIR_W-1:0] DIR_ROW_DEC = 2'd1;
	localparam logic [DIR_W-1:0] DIR_COL_INC = 2'd2;
	localparam logic [DIR_W-1:0] DIR_COL_DEC = 2'd3;

	// outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_NONE  = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_SWAP  = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_PRED  = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_REPRO = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_EMPTY = 3'd4;

	// controller to datapath commands
	typedef struct packed {
		logic clr_wr;   // write one cell of the clearing pass
		logic load;     // capture an accepted item
		logic calc;     // form the active and neighbour addresses
		logic rd_pas;   // read the neighbour cell (else the active cell)
		logic cap_act;  // capture the active cell contents
		logic eval;     // decide the outcome and update the tallies
		logic wr_pas;   // write the neighbour cell if required
		logic wr_act;   // write the active cell if required
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last; // clearing pass is on its last cell
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== src/lppi_ctrl.sv =====
// Controller of the lattice block: sequences the clearing pass and the
// read, decide and write steps of one item. Uses lppi_pkg.
`default_nettype none

module lppi_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire lppi_pkg::ctrl_sts_t   sts,
	output lppi_pkg::ctrl_cmd_t        cmd,
	output logic                       busy,
	output logic                       done
);
	import lppi_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_ADDR  = 9'b000000100,
		ST_RD_A  = 9'b000001000,
		ST_RD_P  = 9'b000010000,
		ST_EVAL  = 9'b000100000,
		ST_WR_P  = 9'b001000000,
		ST_WR_A  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// a new item may enter when idle or while the last result is shown
	assign busy   = !(state_q == ST_IDLE || state_q == ST_DONE);
	assign done   = (state_q == ST_DONE);
	assign accept = start && !busy;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE, ST_DONE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = ST_ADDR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ADDR: begin
				cmd.calc = 1'b1;
				state_d  = ST_RD_A;
			end
			ST_RD_A: begin
				state_d = ST_RD_P;
			end
			ST_RD_P: begin
				cmd.rd_pas  = 1'b1;
				cmd.cap_act = 1'b1;
				state_d     = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_WR_P;
			end
			ST_WR_P: begin
				cmd.wr_pas = 1'b1;
				state_d    = ST_WR_A;
			end
			ST_WR_A: begin
				cmd.wr_act = 1'b1;
				state_d    = ST_DONE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/lppi_dp.sv =====
// Datapath of the lattice block: grid memory, address arithmetic, outcome
// decision, population counters and configuration registers. Uses lppi_pkg.
`default_nettype none

module lppi_dp #(
	parameter int ROWS    = lppi_pkg::DEF_ROWS,
	parameter int COLS    = lppi_pkg::DEF_COLS,
	parameter int SPECIES = lppi_pkg::DEF_SPECIES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire lppi_pkg::ctrl_cmd_t                cmd,
	output lppi_pkg::ctrl_sts_t                     sts,
	input  wire logic [lppi_pkg::REQ_W-1:0]         req_type,
	input  wire logic [lppi_pkg::CRD_W-1:0]         row,
	input  wire logic [lppi_pkg::CRD_W-1:0]         col,
	input  wire logic [lppi_pkg::DIR_W-1:0]         direction,
	input  wire logic [lppi_pkg::DRAW_W-1:0]        action_draw,
	input  wire logic [lppi_pkg::CELL_W-1:0]        write_value,
	input  wire logic                               cfg_we,
	input  wire logic [lppi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lppi_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [lppi_pkg::CELL_W-1:0]             cell_value,
	output logic                                    changed,
	output logic [lppi_pkg::OUTCOME_W-1:0]          outcome,
	output logic [lppi_pkg::CNT_W-1:0]              count_empty,
	output logic [lppi_pkg::CNT_W-1:0]              count_one,
	output logic [lppi_pkg::CNT_W-1:0]              count_two,
	output logic [lppi_pkg::CNT_W-1:0]              count_three,
	output logic [lppi_pkg::CNT_W-1:0]              count_four,
	output logic [lppi_pkg::CNT_W-1:0]              count_five
);
	import lppi_pkg::*;

	localparam int DEPTH  = ROWS * COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLS);
	localparam int CRD_N  = 1 << CRD_W;

	// item registers
	logic [REQ_W-1:0]    req_q;
	logic [CRD_W-1:0]    row_q, col_q;
	logic [DIR_W-1:0]    dir_q;
	logic [DRAW_W-1:0]   draw_q;
	logic [CELL_W-1:0]   wv_q;

	// configuration registers
	logic [PROB_W-1:0]   mob_q, pred_q;
	logic [MATRIX_W-1:0] mtx_q;

	// addresses, memory and captured cells
	logic [RW-1:0]       row_tab [CRD_N];
	logic [CW-1:0]       col_tab [CRD_N];
	logic [RW-1:0]       rr, pr;
	logic [CW-1:0]       cc, pc;
	logic [ADDR_W-1:0]   act_c, pas_c, act_addr_q, pas_addr_q;
	logic [ADDR_W-1:0]   clr_cnt_q, rd_addr, mem_wa;
	logic [CELL_W-1:0]   mem [DEPTH];
	logic [CELL_W-1:0]   rd_data_q, a_q, mem_wd;
	logic                mem_we;

	// decision
	logic [CELL_W-1:0]    a, p;
	logic [5:0]           eat_idx;
	logic                 eats;
	logic [PROB_W:0]      thr;
	logic                 wp_en_c, wa_en_c, tally_en_c, changed_c;
	logic [CELL_W-1:0]    wp_val_c, wa_val_c, cell_c, t_old_c, t_new_c;
	logic [OUTCOME_W-1:0] outcome_c;
	logic                 wp_en_q, wa_en_q;
	logic [CELL_W-1:0]    wp_val_q, wa_val_q;

	logic [CNT_W-1:0]     cnt_q [NUM_CNT];

	// row and column reduction tables over the 8-bit coordinate range
	for (genvar gi = 0; gi < CRD_N; gi++) begin : g_tab
		assign row_tab[gi] = RW'(gi % ROWS);
		assign col_tab[gi] = CW'(gi % COLS);
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			row_q  <= row;
			col_q  <= col;
			dir_q  <= direction;
			draw_q <= action_draw;
			wv_q   <= write_value;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mob_q  <= MOB_RESET;
			pred_q <= PRED_RESET;
			mtx_q  <= MATRIX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOB:    mob_q  <= cfg_data[PROB_W-1:0];
				CFG_PRED:   pred_q <= cfg_data[PROB_W-1:0];
				CFG_MATRIX: mtx_q  <= cfg_data[MATRIX_W-1:0];
				default: ;
			endcase
		end
	end

	// wrapped neighbour and linear addresses
	always_comb begin
		rr = row_tab[row_q];
		cc = col_tab[col_q];
		pr = rr;
		pc = cc;
		case (dir_q)
			DIR_ROW_INC: pr = (rr == RW'(ROWS - 1)) ? '0 : rr + 1'b1;
			DIR_ROW_DEC: pr = (rr == '0) ? RW'(ROWS - 1) : rr - 1'b1;
			DIR_COL_INC: pc = (cc == CW'(COLS - 1)) ? '0 : cc + 1'b1;
			DIR_COL_DEC: pc = (cc == '0) ? CW'(COLS - 1) : cc - 1'b1;
			default: ;
		endcase
		act_c = ADDR_W'(rr) * ADDR_W'(COLS) + ADDR_W'(cc);
		pas_c = ADDR_W'(pr) * ADDR_W'(COLS) + ADDR_W'(pc);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			act_addr_q <= act_c;
			pas_addr_q <= pas_c;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));

	// memory port selection
	assign rd_addr = cmd.rd_pas ? pas_addr_q : act_addr_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_cnt_q;
		mem_wd = '0;
		if (cmd.clr_wr) begin
			mem_we = 1'b1;
		end else if (cmd.wr_pas && wp_en_q) begin
			mem_we = 1'b1;
			mem_wa = pas_addr_q;
			mem_wd = wp_val_q;
		end else if (cmd.wr_act && wa_en_q) begin
			mem_we = 1'b1;
			mem_wa = act_addr_q;
			mem_wd = wa_val_q;
		end
	end

	// grid memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_act) a_q <= rd_data_q;
	end

	// predation matrix lookup
	assign a       = a_q;
	assign p       = rd_data_q;
	assign eat_idx = 6'((6'(a) - 6'd1) * 6'(SPECIES) + 6'(p) - 6'd1);
	assign eats    = (eat_idx < 6'(MATRIX_W)) && mtx_q[eat_idx[4:0]];
	assign thr     = {1'b0, mob_q} + {1'b0, pred_q};

	// outcome decision
	always_comb begin
		wp_en_c    = 1'b0;
		wa_en_c    = 1'b0;
		wp_val_c   = '0;
		wa_val_c   = '0;
		tally_en_c = 1'b0;
		t_old_c    = '0;
		t_new_c    = '0;
		cell_c     = a;
		changed_c  = 1'b0;
		outcome_c  = OUT_NONE;
		case (req_q)
			REQ_WRITE: begin
				if (wv_q <= CELL_W'(SPECIES)) begin
					wa_en_c    = 1'b1;
					wa_val_c   = wv_q;
					tally_en_c = 1'b1;
					t_old_c    = a;
					t_new_c    = wv_q;
					cell_c     = wv_q;
				end
			end
			REQ_INTERACT: begin
				if (a == '0) begin
					outcome_c = OUT_EMPTY;
				end else if ({1'b0, draw_q} < mob_q) begin
					// swap counts as an event whatever the neighbour holds
					wp_en_c   = 1'b1;
					wp_val_c  = a;
					wa_en_c   = 1'b1;
					wa_val_c  = p;
					cell_c    = p;
					changed_c = 1'b1;
					outcome_c = OUT_SWAP;
				end else if ({2'b00, draw_q} <= thr) begin
					if (p != '0 && eats) begin
						wp_en_c    = 1'b1;
						tally_en_c = 1'b1;
						t_old_c    = p;
						changed_c  = 1'b1;
						outcome_c  = OUT_PRED;
					end
				end else if (p == '0) begin
					wp_en_c    = 1'b1;
					wp_val_c   = a;
					tally_en_c = 1'b1;
					t_new_c    = a;
					changed_c  = 1'b1;
					outcome_c  = OUT_REPRO;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			wp_en_q    <= wp_en_c;
			wa_en_q    <= wa_en_c;
			wp_val_q   <= wp_val_c;
			wa_val_q   <= wa_val_c;
			cell_value <= cell_c;
			changed    <= changed_c;
			outcome    <= outcome_c;
		end
	end

	// population counters, wrapping at 17 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= CNT_W'(DEPTH);
			for (int k = 1; k < NUM_CNT; k++) cnt_q[k] <= '0;
		end else if (cmd.eval && tally_en_c) begin
			for (int k = 0; k < NUM_CNT; k++) begin
				cnt_q[k] <= cnt_q[k] + CNT_W'(t_new_c == CELL_W'(k))
					- CNT_W'(t_old_c == CELL_W'(k));
			end
		end
	end

	assign count_empty = cnt_q[0];
	assign count_one   = cnt_q[1];
	assign count_two   = cnt_q[2];
	assign count_three = cnt_q[3];
	assign count_four  = cnt_q[4];
	assign count_five  = cnt_q[5];

endmodule

`default_nettype wire

// ===== src/lattice_predator_prey_interaction.sv =====
// Top level of the lattice predator-prey interaction block.
// Joins lppi_ctrl and lppi_dp; uses lppi_pkg.
//
// Usage:
//  - Items enter on start while busy is low. req_type selects a cell write,
//    an interaction attempt or a cell read; row/col are reduced modulo the
//    grid size and direction picks a wrapping neighbour.
//  - Each item gives one result: done is high for one cycle, and cell_value,
//    changed, outcome and the six counters are valid in that cycle. The
//    receiver has no hold-off; the result fields stay put until the next
//    item reaches its decision step.
//  - Sequence: after the accepting edge an item passes an address step, two
//    registered reads, a decision step, two writes and the result cycle;
//    the single grid memory sets this order. busy drops in the done cycle,
//    so a new item can be taken while a result is shown, not before.
//  - Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data;
//    cfg_ready is always high and each write is registered on the next edge.
//  - After reset the grid is cleared one cell a cycle, all ROWS*COLS cells,
//    with busy high; configuration writes are taken meanwhile.
`default_nettype none

module lattice_predator_prey_interaction #(
	parameter int ROWS    = lppi_pkg::DEF_ROWS,
	parameter int COLS    = lppi_pkg::DEF_COLS,
	parameter int SPECIES = lppi_pkg::DEF_SPECIES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	output logic                                    done,
	input  wire logic [lppi_pkg::REQ_W-1:0]         req_type,
	input  wire logic [lppi_pkg::CRD_W-1:0]         row,
	input  wire logic [lppi_pkg::CRD_W-1:0]         col,
	input  wire logic [lppi_pkg::DIR_W-1:0]         direction,
	input  wire logic [lppi_pkg::DRAW_W-1:0]        action_draw,
	input  wire logic [lppi_pkg::CELL_W-1:0]        write_value,
	output logic [lppi_pkg::CELL_W-1:0]             cell_value,
	output logic                                    changed,
	output logic [lppi_pkg::OUTCOME_W-1:0]          outcome,
	output logic [lppi_pkg::CNT_W-1:0]              count_empty,
	output logic [lppi_pkg::CNT_W-1:0]              count_one,
	output logic [lppi_pkg::CNT_W-1:0]              count_two,
	output logic [lppi_pkg::CNT_W-1:0]              count_three,
	output logic [lppi_pkg::CNT_W-1:0]              count_four,
	output logic [lppi_pkg::CNT_W-1:0]              count_five,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lppi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lppi_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lppi_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic      cfg_we;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	lppi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lppi_dp #(
		.ROWS    (ROWS),
		.COLS    (COLS),
		.SPECIES (SPECIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.row         (row),
		.col         (col),
		.direction   (direction),
		.action_draw (action_draw),
		.write_value (write_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cell_value  (cell_value),
		.changed     (changed),
		.outcome     (outcome),
		.count_empty (count_empty),
		.count_one   (count_one),
		.count_two   (count_two),
		.count_three (count_three),
		.count_four  (count_four),
		.count_five  (count_five)
	);

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a counted event is a swap, a predation or a reproduction
	a_changed_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && changed |->
			(outcome == OUT_SWAP || outcome == OUT_PRED || outcome == OUT_REPRO))
		else $error("event flagged with a non-event outcome");

	// no decision step, item write or result occurs during the clearing pass
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.eval && !cmd.wr_pas && !cmd.wr_act && !done)
		else $error("item work overlapped the clearing pass");

endmodule

`default_nettype wire

// ===== tb/sv/tb_lattice_predator_prey_interaction.sv =====
// Self-checking testbench for the lattice predator-prey interaction block.
// Predicts each result from its own grid, population tallies and register copies;
// depends on lppi_pkg and the lattice_predator_prey_interaction top level.
module tb_lattice_predator_prey_interaction;
	timeunit 1ns;
	timeprecision 1ps;

	import lppi_pkg::*;

	localparam int GRID_ROWS      = DEF_ROWS;
	localparam int GRID_COLS      = DEF_COLS;
	localparam int NUM_SPECIES    = DEF_SPECIES;
	localparam int GRID_CELLS     = GRID_ROWS * GRID_COLS;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int REPORT_LIMIT   = 10;
	localparam int DRAW_MAX       = 65535;

	// request code the block does not define; it behaves as a read
	localparam logic [REQ_W-1:0]    REQ_SPARE  = 2'd3;
	localparam logic [PROB_W-1:0]   PROB_ONE   = 17'd65536;
	localparam logic [PROB_W-1:0]   PROB_ZERO  = 17'd0;
	localparam logic [MATRIX_W-1:0] MATRIX_ALL = '1;
	localparam logic [MATRIX_W-1:0] MATRIX_NONE = '0;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [CRD_W-1:0]  r;
		logic [CRD_W-1:0]  c;
		logic [DIR_W-1:0]  dir;
		logic [DRAW_W-1:0] draw;
		logic [CELL_W-1:0] wval;
	} lattice_item_t;

	typedef struct packed {
		logic [CELL_W-1:0]             cell_val;
		logic                          chg;
		logic [OUTCOME_W-1:0]          outc;
		logic [NUM_CNT-1:0][CNT_W-1:0] counts;
	} lattice_result_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  busy;
	logic                  done;
	logic [REQ_W-1:0]      req_type    = '0;
	logic [CRD_W-1:0]      row         = '0;
	logic [CRD_W-1:0]      col         = '0;
	logic [DIR_W-1:0]      direction   = '0;
	logic [DRAW_W-1:0]     action_draw = '0;
	logic [CELL_W-1:0]     write_value = '0;
	logic [CELL_W-1:0]     cell_value;
	logic                  changed;
	logic [OUTCOME_W-1:0]  outcome;
	logic [CNT_W-1:0]      count_empty;
	logic [CNT_W-1:0]      count_one;
	logic [CNT_W-1:0]      count_two;
	logic [CNT_W-1:0]      count_three;
	logic [CNT_W-1:0]      count_four;
	logic [CNT_W-1:0]      count_five;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// predictor state: grid contents, tallies (0 empty, 1..5 species), registers
	logic [CELL_W-1:0]   lattice_cells [GRID_CELLS];
	int unsigned         population [NUM_CNT];
	logic [PROB_W-1:0]   mob_thresh;
	logic [PROB_W-1:0]   pred_thresh;
	logic [MATRIX_W-1:0] prey_matrix;

	lattice_result_t pending_results [$];
	int unsigned     mismatch_count = 0;
	int unsigned     idle_cycles    = 0;
	bit              gaps_on        = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lattice_predator_prey_interaction #(
		.ROWS    (GRID_ROWS),
		.COLS    (GRID_COLS),
		.SPECIES (NUM_SPECIES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.req_type    (req_type),
		.row         (row),
		.col         (col),
		.direction   (direction),
		.action_draw (action_draw),
		.write_value (write_value),
		.cell_value  (cell_value),
		.changed     (changed),
		.outcome     (outcome),
		.count_empty (count_empty),
		.count_one   (count_one),
		.count_two   (count_two),
		.count_three (count_three),
		.count_four  (count_four),
		.count_five  (count_five),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// load one cell and keep the tallies in step
	function automatic void put_cell(int unsigned idx, logic [CELL_W-1:0] v);
		population[lattice_cells[idx]]--;
		lattice_cells[idx] = v;
		population[v]++;
	endfunction

	// apply one item to the predictor and return the result it should give
	function automatic lattice_result_t predict_lattice_step(lattice_item_t it);
		lattice_result_t   res;
		int unsigned       r, c, nr, nc, act, nbr, draw, bitpos, lim_swap, lim_pred;
		logic [CELL_W-1:0] a, p;
		r = it.r % GRID_ROWS;
		c = it.c % GRID_COLS;
		act = r * GRID_COLS + c;
		res = '0;
		res.outc = OUT_NONE;
		case (it.req)
			REQ_WRITE: begin
				if (it.wval <= NUM_SPECIES)
					put_cell(act, it.wval);
			end
			REQ_INTERACT: begin
				a = lattice_cells[act];
				if (a == '0) begin
					res.outc = OUT_EMPTY;
				end else begin
					nr = r;
					nc = c;
					case (it.dir)
						DIR_ROW_INC: nr = (r + 1) % GRID_ROWS;
						DIR_ROW_DEC: nr = (r + GRID_ROWS - 1) % GRID_ROWS;
						DIR_COL_INC: nc = (c + 1) % GRID_COLS;
						default:     nc = (c + GRID_COLS - 1) % GRID_COLS;
					endcase
					nbr = nr * GRID_COLS + nc;
					p = lattice_cells[nbr];
					draw = it.draw;
					lim_swap = mob_thresh;
					lim_pred = lim_swap + pred_thresh;
					if (draw < lim_swap) begin
						// swap keeps the tallies, even with an empty or equal neighbour
						lattice_cells[nbr] = a;
						lattice_cells[act] = p;
						res.chg = 1'b1;
						res.outc = OUT_SWAP;
					end else if (draw <= lim_pred) begin
						if (p != '0) begin
							bitpos = (int'(a) - 1) * NUM_SPECIES + (int'(p) - 1);
							if (bitpos < MATRIX_W && prey_matrix[bitpos]) begin
								put_cell(nbr, '0);
								res.chg = 1'b1;
								res.outc = OUT_PRED;
							end
						end
					end else if (p == '0) begin
						put_cell(nbr, a);
						res.chg = 1'b1;
						res.outc = OUT_REPRO;
					end
				end
			end
			default: ; // read, and the spare code taken as a read
		endcase
		res.cell_val = lattice_cells[act];
		for (int k = 0; k < NUM_CNT; k++)
			res.counts[k] = CNT_W'(population[k]);
		return res;
	endfunction

	function automatic lattice_item_t mk_item(logic [REQ_W-1:0] req, int unsigned r,
			int unsigned c, logic [DIR_W-1:0] dir, int unsigned draw,
			logic [CELL_W-1:0] wval);
		lattice_item_t it;
		it.req = req;
		it.r = CRD_W'(r);
		it.c = CRD_W'(c);
		it.dir = dir;
		it.draw = DRAW_W'(draw);
		it.wval = wval;
		return it;
	endfunction

	// mostly short gaps, a few long ones, none while gaps are switched off
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	// item aimed at a small window of the grid, so cells get populated and interact
	function automatic lattice_item_t random_item(int unsigned base_r, int unsigned base_c,
			int unsigned span);
		lattice_item_t it;
		int unsigned   roll, thr;
		it.req = REQ_INTERACT;
		it.r = CRD_W'(base_r + $urandom_range(span - 1));
		it.c = CRD_W'(base_c + $urandom_range(span - 1));
		it.dir = DIR_W'($urandom_range(3));
		it.draw = DRAW_W'($urandom);
		it.wval = CELL_W'($urandom_range(NUM_SPECIES));
		roll = $urandom_range(99);
		if (roll < 25) begin
			it.req = REQ_WRITE;
		end else if (roll < 28) begin
			it.req = REQ_WRITE;
			it.wval = CELL_W'($urandom_range(7, NUM_SPECIES + 1));
		end else if (roll < 36) begin
			it.req = REQ_READ;
		end else if (roll < 39) begin
			it.req = REQ_SPARE;
		end else if (roll < 44) begin
			// anywhere on the grid, any request code
			it.req = REQ_W'($urandom_range(3));
			it.r = CRD_W'($urandom);
			it.c = CRD_W'($urandom);
			it.wval = CELL_W'($urandom);
		end else if (roll < 54) begin
			// draw at or next to one of the two thresholds
			thr = ($urandom_range(1) != 0) ? mob_thresh : mob_thresh + pred_thresh;
			thr = thr + $urandom_range(2);
			thr = (thr == 0) ? 0 : thr - 1;
			it.draw = DRAW_W'((thr > DRAW_MAX) ? DRAW_MAX : thr);
		end
		return it;
	endfunction

	// present one item, wait for acceptance and file its expected result
	task automatic send_item(lattice_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= it.req;
		row         <= it.r;
		col         <= it.c;
		direction   <= it.dir;
		action_draw <= it.draw;
		write_value <= it.wval;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(predict_lattice_step(it));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_MOB:    mob_thresh = val[PROB_W-1:0];
			CFG_PRED:   pred_thresh = val[PROB_W-1:0];
			CFG_MATRIX: prey_matrix = val[MATRIX_W-1:0];
			default: ;
		endcase
	endtask

	// registers change only once the block has delivered everything
	task automatic load_registers(logic [PROB_W-1:0] mob, logic [PROB_W-1:0] pred,
			logic [MATRIX_W-1:0] matrix);
		drain_results();
		write_reg(CFG_MOB, CFG_DATA_W'(mob));
		write_reg(CFG_PRED, CFG_DATA_W'(pred));
		write_reg(CFG_MATRIX, CFG_DATA_W'(matrix));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_lattice_phase(int unsigned n_items);
		int unsigned base_r, base_c, span;
		span = ($urandom_range(3) == 0) ? 8 : 4;
		// windows near the last row/column exercise the wrap-around
		base_r = ($urandom_range(3) == 0) ? GRID_ROWS - 2 : $urandom_range(GRID_ROWS - 1);
		base_c = ($urandom_range(3) == 0) ? GRID_COLS - 2 : $urandom_range(GRID_COLS - 1);
		gaps_on = ($urandom_range(4) != 0);
		repeat (n_items)
			send_item(random_item(base_r, base_c, span));
	endtask

	// hand-picked items under the reset register values
	task automatic test_directed_cases();
		send_item(mk_item(REQ_READ, 0, 0, DIR_ROW_INC, 0, 0));
		send_item(mk_item(REQ_INTERACT, 0, 0, DIR_ROW_INC, 0, 0));     // empty active cell
		send_item(mk_item(REQ_WRITE, 255, 255, DIR_ROW_INC, 0, 1));
		send_item(mk_item(REQ_WRITE, 0, 255, DIR_ROW_INC, 0, 2));
		send_item(mk_item(REQ_WRITE, 255, 0, DIR_ROW_INC, 0, 5));
		send_item(mk_item(REQ_WRITE, 255, 255, DIR_ROW_INC, 0, 6));   // out of range, ignored
		send_item(mk_item(REQ_WRITE, 255, 255, DIR_ROW_INC, 0, 7));
		send_item(mk_item(REQ_SPARE, 255, 255, DIR_ROW_INC, DRAW_MAX, 7));
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_ROW_INC, 40000, 0)); // predation, wraps
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_ROW_INC, 40000, 0)); // prey now gone
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_COL_INC, 40000, 0)); // matrix bit clear
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_ROW_INC, 49153, 0)); // reproduction
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_COL_INC, DRAW_MAX, 0)); // occupied
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_ROW_DEC, 0, 0));     // swap with empty
		send_item(mk_item(REQ_INTERACT, 254, 255, DIR_ROW_INC, 32767, 0)); // swap back
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_ROW_INC, 32768, 0)); // lowest predation
		send_item(mk_item(REQ_INTERACT, 255, 255, DIR_ROW_INC, 0, 0));     // swap equal cells
		send_item(mk_item(REQ_WRITE, 0, 0, DIR_ROW_INC, 0, 3));
		send_item(mk_item(REQ_INTERACT, 0, 0, DIR_ROW_DEC, 49152, 0));   // highest predation
		send_item(mk_item(REQ_INTERACT, 0, 0, DIR_COL_DEC, 50000, 0));   // wraps to last col
		send_item(mk_item(REQ_INTERACT, 0, 0, DIR_COL_INC, 50000, 0));
		send_item(mk_item(REQ_WRITE, 0, 0, DIR_ROW_INC, 0, 0));
		send_item(mk_item(REQ_WRITE, 170, 85, DIR_COL_DEC, 0, 4));
		send_item(mk_item(REQ_READ, 170, 85, DIR_COL_DEC, 0, 0));
		send_item(mk_item(REQ_INTERACT, 0, 0, DIR_COL_INC, 0, 0));       // cleared active cell
	endtask

	// corner settings of the thresholds and the predation matrix
	task automatic test_register_extremes();
		load_registers(PROB_ZERO, PROB_ZERO, MATRIX_NONE);
		run_lattice_phase(60);
		load_registers(PROB_ONE, PROB_ONE, MATRIX_ALL);
		run_lattice_phase(60);
		load_registers(PROB_ZERO, PROB_ONE, MATRIX_ALL);
		run_lattice_phase(60);
		load_registers(PROB_ONE, PROB_ZERO, MATRIX_NONE);
		run_lattice_phase(60);
		load_registers(PROB_ZERO, PROB_ZERO, MATRIX_ALL);
		run_lattice_phase(60);
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 9)
				load_registers(MOB_RESET, PRED_RESET, MATRIX_RESET);
			else
				load_registers(PROB_W'($urandom_range(65536)), PROB_W'($urandom_range(65536)),
					MATRIX_W'($urandom));
			run_lattice_phase(120);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		lattice_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result with no item outstanding", $time);
			end else begin
				want = pending_results.pop_front();
				check_field("cell_value", want.cell_val, cell_value);
				check_field("changed", want.chg, changed);
				check_field("outcome", want.outc, outcome);
				check_field("count_empty", want.counts[0], count_empty);
				check_field("count_one", want.counts[1], count_one);
				check_field("count_two", want.counts[2], count_two);
				check_field("count_three", want.counts[3], count_three);
				check_field("count_four", want.counts[4], count_four);
				check_field("count_five", want.counts[5], count_five);
			end
		end
	end

	// watchdog: the clearing pass after reset is the longest quiet stretch
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1 ||
				(cfg_valid && cfg_ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		foreach (lattice_cells[i])
			lattice_cells[i] = '0;
		foreach (population[k])
			population[k] = 0;
		population[0] = GRID_CELLS;
		mob_thresh = MOB_RESET;
		pred_thresh = PRED_RESET;
		prey_matrix = MATRIX_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_register_extremes();
		test_random_settings();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/lppi_pkg.sv
src/lppi_ctrl.sv
src/lppi_dp.sv
src/lattice_predator_prey_interaction.sv
tb/sv/tb_lattice_predator_prey_interaction.sv
